// File: rtl/sbss_pkg.sv
// ----------------------------------------------------------------------------
// sbss_pkg
// Shared types and constants of the batch statement splitter: item formats,
// byte classes, status codes and queue sizing.
// ----------------------------------------------------------------------------
package sbss_pkg;

  // widths of the offsets, lengths, statement counter and status code
  localparam int unsigned POS_BITS  = 20;
  localparam int unsigned STMT_BITS = 16;
  localparam int unsigned STAT_BITS = 3;

  localparam logic [POS_BITS-1:0]  POS_MAX  = {POS_BITS{1'b1}};
  localparam logic [STMT_BITS-1:0] STMT_MAX = {STMT_BITS{1'b1}};

  // characters with a meaning of their own
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // status codes
  localparam logic [STAT_BITS-1:0] ST_OK          = 3'd0;
  localparam logic [STAT_BITS-1:0] ST_EMPTY_STMT  = 3'd1;
  localparam logic [STAT_BITS-1:0] ST_OPEN_STRING = 3'd2;
  localparam logic [STAT_BITS-1:0] ST_NO_SEMI     = 3'd3;
  localparam logic [STAT_BITS-1:0] ST_EMPTY_BATCH = 3'd4;

  // decoupling queues: depth is a power of two so the pointers wrap
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QPTR_BITS = $clog2(QDEPTH);
  localparam int unsigned QCNT_BITS = $clog2(QDEPTH + 1);

  // input item
  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_batch;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [POS_BITS-1:0]  stmt_start;
    logic [POS_BITS-1:0]  stmt_length;
    logic [STMT_BITS-1:0] stmt_number;
    logic [STAT_BITS-1:0] status;
    logic                 is_final;
  } out_item_t;

  // byte classes handed from the front to the back
  typedef enum logic [2:0] {
    CLS_END,
    CLS_QUOTE,
    CLS_SEMI,
    CLS_BLANK,
    CLS_TEXT
  } cls_e;

  // classified item
  typedef struct packed {
    cls_e cls;
  } tok_t;

  // handshake between front and back
  typedef struct packed {
    logic valid;
    tok_t tok;
  } tok_chan_t;

endpackage

// File: rtl/sbss_front.sv
// ----------------------------------------------------------------------------
// sbss_front
// Accepts batch bytes, classifies each one and holds the classes in a short
// queue for the back end.
// ----------------------------------------------------------------------------
module sbss_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  sbss_pkg::in_item_t  in_item_i,
  output sbss_pkg::tok_chan_t tok_o,
  input  logic                tok_ready_i
);

  sbss_pkg::tok_t                      mem_q [sbss_pkg::QDEPTH];
  logic [sbss_pkg::QPTR_BITS-1:0]      wr_ptr_q, wr_ptr_d;
  logic [sbss_pkg::QPTR_BITS-1:0]      rd_ptr_q, rd_ptr_d;
  logic [sbss_pkg::QCNT_BITS-1:0]      cnt_q, cnt_d;
  logic                                wr_en, rd_en;
  sbss_pkg::tok_t                      tok_new;

  // byte classification
  always_comb begin
    if (in_item_i.end_of_batch) begin
      tok_new.cls = sbss_pkg::CLS_END;
    end else if (in_item_i.byte_value == sbss_pkg::CH_QUOTE) begin
      tok_new.cls = sbss_pkg::CLS_QUOTE;
    end else if (in_item_i.byte_value == sbss_pkg::CH_SEMI) begin
      tok_new.cls = sbss_pkg::CLS_SEMI;
    end else if (in_item_i.byte_value == sbss_pkg::CH_SPACE ||
                 (in_item_i.byte_value >= sbss_pkg::CH_TAB &&
                  in_item_i.byte_value <= sbss_pkg::CH_CR)) begin
      tok_new.cls = sbss_pkg::CLS_BLANK;
    end else begin
      tok_new.cls = sbss_pkg::CLS_TEXT;
    end
  end

  // queue control
  assign full        = (cnt_q == sbss_pkg::QCNT_BITS'(sbss_pkg::QDEPTH));
  assign wr_en       = push && !full;
  assign tok_o.valid = (cnt_q != '0);
  assign tok_o.tok   = mem_q[rd_ptr_q];
  assign rd_en       = tok_o.valid && tok_ready_i;

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + sbss_pkg::QPTR_BITS'(1) : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + sbss_pkg::QPTR_BITS'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + sbss_pkg::QCNT_BITS'(1);
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - sbss_pkg::QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= tok_new;
    end
  end

endmodule

// File: rtl/sbss_back.sv
// ----------------------------------------------------------------------------
// sbss_back
// Runs the splitter state on the classified items and queues the statement
// and end-of-batch results for the consumer.
// ----------------------------------------------------------------------------
module sbss_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sbss_pkg::tok_chan_t tok_i,
  output logic                tok_ready_o,
  output logic                empty,
  input  logic                pop,
  output sbss_pkg::out_item_t out_item_o
);

  localparam int unsigned LEN_BITS = sbss_pkg::POS_BITS + 1;

  // splitter state
  logic [sbss_pkg::POS_BITS-1:0]  position_q, position_d;
  logic                           in_string_q, in_string_d;
  logic [sbss_pkg::POS_BITS-1:0]  first_q, first_d;
  logic [sbss_pkg::POS_BITS-1:0]  last_q, last_d;
  logic                           has_content_q, has_content_d;
  logic [sbss_pkg::STMT_BITS-1:0] stmt_count_q, stmt_count_d;
  logic                           found_any_q, found_any_d;
  logic [sbss_pkg::STAT_BITS-1:0] failed_q, failed_d;

  // result queue
  sbss_pkg::out_item_t            mem_q [sbss_pkg::QDEPTH];
  logic [sbss_pkg::QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [sbss_pkg::QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [sbss_pkg::QCNT_BITS-1:0] cnt_q, cnt_d;
  logic                           rd_en;

  logic                           fire;
  logic                           res_valid;
  sbss_pkg::out_item_t            res;
  logic                           note;
  logic [LEN_BITS-1:0]            len_raw;
  logic [sbss_pkg::POS_BITS-1:0]  len_sat;
  logic [sbss_pkg::STAT_BITS-1:0] final_status;

  assign tok_ready_o = (cnt_q != sbss_pkg::QCNT_BITS'(sbss_pkg::QDEPTH));
  assign fire        = tok_i.valid && tok_ready_o;

  // trimmed length of the open statement, saturating
  always_comb begin
    len_raw = {1'b0, last_q} - {1'b0, first_q} + LEN_BITS'(1);
    if (last_q < first_q) begin
      len_sat = '0;
    end else if (len_raw > {1'b0, sbss_pkg::POS_MAX}) begin
      len_sat = sbss_pkg::POS_MAX;
    end else begin
      len_sat = len_raw[sbss_pkg::POS_BITS-1:0];
    end
  end

  // end-of-batch status, earlier failure first
  always_comb begin
    priority if (failed_q != sbss_pkg::ST_OK) begin
      final_status = failed_q;
    end else if (in_string_q) begin
      final_status = sbss_pkg::ST_OPEN_STRING;
    end else if (has_content_q) begin
      final_status = sbss_pkg::ST_NO_SEMI;
    end else if (!found_any_q) begin
      final_status = sbss_pkg::ST_EMPTY_BATCH;
    end else begin
      final_status = sbss_pkg::ST_OK;
    end
  end

  // state update for one classified item
  always_comb begin
    position_d    = position_q;
    in_string_d   = in_string_q;
    first_d       = first_q;
    last_d        = last_q;
    has_content_d = has_content_q;
    stmt_count_d  = stmt_count_q;
    found_any_d   = found_any_q;
    failed_d      = failed_q;
    res_valid     = 1'b0;
    res           = '0;
    note          = 1'b0;

    if (fire) begin
      if (tok_i.tok.cls == sbss_pkg::CLS_END) begin
        res_valid       = 1'b1;
        res.stmt_number = stmt_count_q;
        res.status      = final_status;
        res.is_final    = 1'b1;
        // re-arm for the next batch
        position_d      = '0;
        in_string_d     = 1'b0;
        first_d         = '0;
        last_d          = '0;
        has_content_d   = 1'b0;
        stmt_count_d    = sbss_pkg::STMT_BITS'(1);
        found_any_d     = 1'b0;
        failed_d        = sbss_pkg::ST_OK;
      end else if (failed_q == sbss_pkg::ST_OK) begin
        if (tok_i.tok.cls == sbss_pkg::CLS_QUOTE) begin
          in_string_d = !in_string_q;
          note        = 1'b1;
        end else if (tok_i.tok.cls == sbss_pkg::CLS_SEMI && !in_string_q) begin
          if (!has_content_q) begin
            failed_d = sbss_pkg::ST_EMPTY_STMT;
          end else begin
            res_valid       = 1'b1;
            res.stmt_start  = first_q;
            res.stmt_length = len_sat;
            res.stmt_number = stmt_count_q;
            res.status      = sbss_pkg::ST_OK;
            res.is_final    = 1'b0;
            has_content_d   = 1'b0;
            found_any_d     = 1'b1;
            if (stmt_count_q != sbss_pkg::STMT_MAX) begin
              stmt_count_d = stmt_count_q + sbss_pkg::STMT_BITS'(1);
            end
          end
        end else if (tok_i.tok.cls != sbss_pkg::CLS_BLANK) begin
          note = 1'b1;
        end

        // track first and last non-space byte
        if (note) begin
          if (!has_content_q) begin
            first_d       = position_q;
            has_content_d = 1'b1;
          end
          last_d = position_q;
        end

        if (position_q != sbss_pkg::POS_MAX) begin
          position_d = position_q + sbss_pkg::POS_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q    <= '0;
      in_string_q   <= 1'b0;
      first_q       <= '0;
      last_q        <= '0;
      has_content_q <= 1'b0;
      stmt_count_q  <= sbss_pkg::STMT_BITS'(1);
      found_any_q   <= 1'b0;
      failed_q      <= sbss_pkg::ST_OK;
    end else begin
      position_q    <= position_d;
      in_string_q   <= in_string_d;
      first_q       <= first_d;
      last_q        <= last_d;
      has_content_q <= has_content_d;
      stmt_count_q  <= stmt_count_d;
      found_any_q   <= found_any_d;
      failed_q      <= failed_d;
    end
  end

  // result queue control
  assign empty      = (cnt_q == '0);
  assign out_item_o = mem_q[rd_ptr_q];
  assign rd_en      = pop && !empty;

  always_comb begin
    wr_ptr_d = res_valid ? wr_ptr_q + sbss_pkg::QPTR_BITS'(1) : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + sbss_pkg::QPTR_BITS'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (res_valid && !rd_en) begin
      cnt_d = cnt_q + sbss_pkg::QCNT_BITS'(1);
    end else if (!res_valid && rd_en) begin
      cnt_d = cnt_q - sbss_pkg::QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // result storage
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      mem_q[wr_ptr_q] <= res;
    end
  end

endmodule

// File: rtl/sql_batch_statement_splitter.sv
// ----------------------------------------------------------------------------
// sql_batch_statement_splitter
// Splits a byte stream into statements at semicolons outside quoted strings.
// ----------------------------------------------------------------------------
// One byte is taken per clock and, with the result side draining, one item
// is accepted every cycle. A byte is held in the front queue before it
// reaches the state logic, and its result, if any, is written into the
// result queue, whose head drives the result ports; the back end updates
// position, quote flag and trim markers for each item as it is taken, which
// sets that rate. Each statement comes out as start offset, trimmed length
// and number; the end item gives one final result with the batch status and
// re-arms the block. After an error the remaining bytes up to the end item
// are dropped. Both sides have a two-entry queue, so a stalled consumer
// holds back the input only once both are full.
// ----------------------------------------------------------------------------
module sql_batch_statement_splitter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  sbss_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output sbss_pkg::out_item_t out_item_o
);

  sbss_pkg::tok_chan_t tok;
  logic                tok_ready;

  // byte intake and classification
  sbss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .tok_o       (tok),
    .tok_ready_i (tok_ready)
  );

  // statement tracking and result queue
  sbss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (tok),
    .tok_ready_o (tok_ready),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule

// File: rtl/sbss_checker.sv
// ----------------------------------------------------------------------------
// sbss_checker
// Port-level checks of the statement splitter, bound to the top level.
// ----------------------------------------------------------------------------
module sbss_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                push,
  input logic                full,
  input sbss_pkg::in_item_t  in_item_i,
  input logic                empty,
  input logic                pop,
  input sbss_pkg::out_item_t out_item_o
);

  // a statement result always carries ok status
  a_stmt_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.is_final) |-> (out_item_o.status == sbss_pkg::ST_OK))
    else $error("statement result with non-ok status");

  // a statement reported is never empty after trimming
  a_stmt_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.is_final) |-> (out_item_o.stmt_length != '0))
    else $error("statement result with zero length");

  // the final result has no offset or length and a nonzero number
  a_final_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.is_final) |->
      (out_item_o.stmt_start == '0 && out_item_o.stmt_length == '0 &&
       out_item_o.stmt_number != '0))
    else $error("final result with offset, length or zero number");

  // a waiting result holds until taken
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("waiting result changed before pop");

endmodule

bind sql_batch_statement_splitter sbss_checker u_sbss_checker (.*);

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the batch statement splitter. A directed table
// covers the empty batch, quotes with doubled quotes, every error status and
// the byte extremes. Random batches follow: mostly well-formed statements
// with random words, blanks and quoted strings, plus broken batches and
// noise. Each accepted byte goes through a local model of the splitter, and
// every popped report is compared field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // directed row: an item and, where it is obvious, its report typed in
  typedef struct {
    sbss_pkg::in_item_t  item;
    bit                  typed;
    sbss_pkg::out_item_t want;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni   = 1'b0;
  logic                push     = 1'b0;
  logic                pop      = 1'b0;
  sbss_pkg::in_item_t  in_item  = '0;
  logic                full;
  logic                empty;
  sbss_pkg::out_item_t out_item;

  // local copy of the splitter state
  logic [sbss_pkg::POS_BITS-1:0]  pos;
  logic                           in_str;
  logic [sbss_pkg::POS_BITS-1:0]  first_c;
  logic [sbss_pkg::POS_BITS-1:0]  last_c;
  logic                           has_c;
  logic [sbss_pkg::STMT_BITS-1:0] stmt_no;
  logic                           found;
  logic [sbss_pkg::STAT_BITS-1:0] fail_code;

  sbss_pkg::out_item_t report_q[$];
  dir_row_t            dir_rows[$];
  logic [7:0]          byte_q[$];

  int  mismatches   = 0;
  int  items_sent   = 0;
  int  n_stmt_reps  = 0;
  int  n_final[5]   = '{default: 0};
  bit  rx_calm      = 1'b0;
  bit  tx_calm      = 1'b0;

  sql_batch_statement_splitter DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic sbss_pkg::out_item_t mk_report(
      input logic [sbss_pkg::POS_BITS-1:0]  start,
      input logic [sbss_pkg::POS_BITS-1:0]  len,
      input logic [sbss_pkg::STMT_BITS-1:0] num,
      input logic [sbss_pkg::STAT_BITS-1:0] st,
      input logic                           fin);
    sbss_pkg::out_item_t r;
    r.stmt_start  = start;
    r.stmt_length = len;
    r.stmt_number = num;
    r.status      = st;
    r.is_final    = fin;
    return r;
  endfunction

  function automatic void clear_splitter();
    pos       = '0;
    in_str    = 1'b0;
    first_c   = '0;
    last_c    = '0;
    has_c     = 1'b0;
    stmt_no   = 16'd1;
    found     = 1'b0;
    fail_code = sbss_pkg::ST_OK;
  endfunction

  function automatic bit is_blank(input logic [7:0] b);
    return b == sbss_pkg::CH_SPACE || (b >= sbss_pkg::CH_TAB && b <= sbss_pkg::CH_CR);
  endfunction

  function automatic void mark_content();
    if (!has_c) begin
      first_c = pos;
      has_c   = 1'b1;
    end
    last_c = pos;
  endfunction

  // advance the local state by one item; returns 1 when a report is due
  function automatic bit next_report(input sbss_pkg::in_item_t it,
                                     output sbss_pkg::out_item_t rep);
    logic [sbss_pkg::POS_BITS:0]    span;
    logic [sbss_pkg::STAT_BITS-1:0] st;
    bit                             due;
    rep = '0;
    due = 1'b0;
    if (it.end_of_batch) begin
      if (fail_code != sbss_pkg::ST_OK) st = fail_code;
      else if (in_str)                  st = sbss_pkg::ST_OPEN_STRING;
      else if (has_c)                   st = sbss_pkg::ST_NO_SEMI;
      else if (!found)                  st = sbss_pkg::ST_EMPTY_BATCH;
      else                              st = sbss_pkg::ST_OK;
      rep = mk_report('0, '0, stmt_no, st, 1'b1);
      clear_splitter();
      return 1'b1;
    end
    if (fail_code != sbss_pkg::ST_OK) return 1'b0;
    if (it.byte_value == sbss_pkg::CH_QUOTE) begin
      in_str = ~in_str;
      mark_content();
    end else if (!in_str && it.byte_value == sbss_pkg::CH_SEMI) begin
      if (!has_c) begin
        fail_code = sbss_pkg::ST_EMPTY_STMT;
      end else begin
        span = {1'b0, last_c} - {1'b0, first_c} + (sbss_pkg::POS_BITS + 1)'(1);
        if (last_c < first_c) span = '0;
        if (span > {1'b0, sbss_pkg::POS_MAX}) span = {1'b0, sbss_pkg::POS_MAX};
        rep   = mk_report(first_c, span[sbss_pkg::POS_BITS-1:0], stmt_no,
                          sbss_pkg::ST_OK, 1'b0);
        due   = 1'b1;
        has_c = 1'b0;
        found = 1'b1;
        if (stmt_no != sbss_pkg::STMT_MAX) stmt_no++;
      end
    end else if (!is_blank(it.byte_value)) begin
      mark_content();
    end
    if (pos != sbss_pkg::POS_MAX) pos++;
    return due;
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want_v);
    if (mismatches < 40)
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want_v, $time);
    mismatches++;
  endtask

  // push one item after a gap and run it through the local model
  task automatic send_item(input sbss_pkg::in_item_t it, input int gap, input bit typed,
                           input sbss_pkg::out_item_t want);
    sbss_pkg::out_item_t rep;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full);
    items_sent++;
    if (next_report(it, rep)) report_q.push_back(typed ? want : rep);
  endtask

  function automatic int draw_gap();
    return tx_calm ? 0 : $urandom_range(0, 17);
  endfunction

  task automatic add_row(input logic [7:0] b, input logic eob, input bit typed,
                         input sbss_pkg::out_item_t want);
    dir_row_t r;
    r.item.byte_value   = b;
    r.item.end_of_batch = eob;
    r.typed             = typed;
    r.want              = want;
    dir_rows.push_back(r);
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) add_row(s[i], 1'b0, 1'b0, '0);
  endtask

  // random batch pieces
  task automatic add_blanks();
    logic [7:0] pick[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    int n;
    n = $urandom_range(0, 2);
    repeat (n) byte_q.push_back(pick[$urandom_range(0, 5)]);
  endtask

  task automatic add_word();
    logic [7:0] b;
    int n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      do b = 8'($urandom_range(0, 255));
      while (is_blank(b) || b == sbss_pkg::CH_QUOTE || b == sbss_pkg::CH_SEMI);
      byte_q.push_back(b);
    end
  endtask

  task automatic add_quoted();
    logic [7:0] b;
    int n;
    n = $urandom_range(0, 4);
    byte_q.push_back(sbss_pkg::CH_QUOTE);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) begin
        byte_q.push_back(sbss_pkg::CH_QUOTE);
        byte_q.push_back(sbss_pkg::CH_QUOTE);
      end else begin
        do b = 8'($urandom_range(0, 255)); while (b == sbss_pkg::CH_QUOTE);
        byte_q.push_back(b);
      end
    end
    byte_q.push_back(sbss_pkg::CH_QUOTE);
  endtask

  task automatic add_body();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) add_quoted();
      else add_word();
      add_blanks();
    end
  endtask

  // one batch: well-formed statements, optionally broken at the tail
  task automatic build_batch();
    int kind;
    int n_stmt;
    byte_q.delete();
    kind   = $urandom_range(0, 9);
    n_stmt = $urandom_range(0, 5);
    repeat (n_stmt) begin
      add_blanks();
      add_body();
      byte_q.push_back(sbss_pkg::CH_SEMI);
    end
    add_blanks();
    case (kind)
      6: begin
        // noise of any byte value
        repeat ($urandom_range(1, 10)) byte_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 0) byte_q.push_back(sbss_pkg::CH_SEMI);
      end
      7: byte_q.push_back(sbss_pkg::CH_SEMI);
      8: add_body();
      9: begin
        byte_q.push_back(sbss_pkg::CH_QUOTE);
        add_word();
      end
      default: ;
    endcase
  endtask

  // result side: stall per report, with calm stretches
  initial begin : drain_reports
    int stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 17);
      if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  // compare every popped report with the oldest one awaited
  always @(posedge clk_i) begin : check_reports
    sbss_pkg::out_item_t want;
    if (rst_ni && pop && !empty) begin
      if (report_q.size() == 0) begin
        flag_mismatch("report with none awaited", 64'(out_item), 64'd0);
      end else begin
        want = report_q.pop_front();
        if (out_item.stmt_start !== want.stmt_start)
          flag_mismatch("stmt_start", 64'(out_item.stmt_start), 64'(want.stmt_start));
        if (out_item.stmt_length !== want.stmt_length)
          flag_mismatch("stmt_length", 64'(out_item.stmt_length),
                        64'(want.stmt_length));
        if (out_item.stmt_number !== want.stmt_number)
          flag_mismatch("stmt_number", 64'(out_item.stmt_number),
                        64'(want.stmt_number));
        if (out_item.status !== want.status)
          flag_mismatch("status", 64'(out_item.status), 64'(want.status));
        if (out_item.is_final !== want.is_final)
          flag_mismatch("is_final", 64'(out_item.is_final), 64'(want.is_final));
        if (want.is_final) n_final[want.status]++;
        else n_stmt_reps++;
      end
    end
  end

  // stimulus
  initial begin : run_batches
    sbss_pkg::in_item_t it;
    clear_splitter();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    add_row(8'h00, 1'b1, 1'b1,
            mk_report('0, '0, 16'd1, sbss_pkg::ST_EMPTY_BATCH, 1'b1));
    add_row("a", 1'b0, 1'b0, '0);
    add_row(sbss_pkg::CH_SEMI, 1'b0, 1'b1,
            mk_report('0, 20'd1, 16'd1, sbss_pkg::ST_OK, 1'b0));
    add_row(8'hFF, 1'b1, 1'b1, mk_report('0, '0, 16'd2, sbss_pkg::ST_OK, 1'b1));
    // doubled quote inside a string, semicolon inside a string, trimming
    add_text(" \t'x;''y' ");
    add_row(sbss_pkg::CH_SEMI, 1'b0, 1'b0, '0);
    add_row(8'h5A, 1'b1, 1'b1, mk_report('0, '0, 16'd2, sbss_pkg::ST_OK, 1'b1));
    // empty statement, then bytes dropped until the end item
    add_row(sbss_pkg::CH_SEMI, 1'b0, 1'b0, '0);
    add_row("z", 1'b0, 1'b0, '0);
    add_row(8'hA5, 1'b1, 1'b1,
            mk_report('0, '0, 16'd1, sbss_pkg::ST_EMPTY_STMT, 1'b1));
    // unterminated string
    add_row(sbss_pkg::CH_QUOTE, 1'b0, 1'b0, '0);
    add_row(8'h3C, 1'b1, 1'b1,
            mk_report('0, '0, 16'd1, sbss_pkg::ST_OPEN_STRING, 1'b1));
    // byte extremes as text with no final semicolon
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'hC3, 1'b1, 1'b1, mk_report('0, '0, 16'd1, sbss_pkg::ST_NO_SEMI, 1'b1));
    foreach (dir_rows[i])
      send_item(dir_rows[i].item, draw_gap(), dir_rows[i].typed, dir_rows[i].want);

    // hold off until every report has come
    push <= 1'b0;
    do @(posedge clk_i); while (report_q.size() != 0);

    // random batches
    while (items_sent < 850) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) begin
        push <= 1'b0;
        do @(posedge clk_i); while (report_q.size() != 0);
      end
      build_batch();
      foreach (byte_q[k]) begin
        it.byte_value   = byte_q[k];
        it.end_of_batch = 1'b0;
        send_item(it, draw_gap(), 1'b0, '0);
      end
      it.byte_value   = 8'($urandom_range(0, 255));
      it.end_of_batch = 1'b1;
      send_item(it, draw_gap(), 1'b0, '0);
    end
    push <= 1'b0;

    // wait for the tail of the reports
    do @(posedge clk_i); while (report_q.size() != 0);
    repeat (8) @(posedge clk_i);

    $display("covered %0d items, %0d statement reports, random gaps on both sides",
             items_sent, n_stmt_reps);
    $display("batch ends: ok %0d, empty stmt %0d, open string %0d, no semicolon %0d, empty %0d",
             n_final[sbss_pkg::ST_OK], n_final[sbss_pkg::ST_EMPTY_STMT],
             n_final[sbss_pkg::ST_OPEN_STRING], n_final[sbss_pkg::ST_NO_SEMI],
             n_final[sbss_pkg::ST_EMPTY_BATCH]);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
